// ===== hdl/sobel_pkg.sv =====
package sobel_pkg;

	// Configuration register indexes and width.
	localparam int unsigned CFG_W = 11;
	localparam logic CFG_IMAGE_WIDTH = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// Item kinds carried on the input tuser bit.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam int unsigned PIX_W = 8;
	localparam int unsigned RGB_W = 3 * PIX_W;
	localparam int unsigned SUM_W = 21;
	localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
	localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_LD,
		ST_SQ,
		ST_ROOT,
		ST_OUT
	} state_t;

	// Per-lane control from the sequencer.
	typedef struct packed {
		logic       sq_en;
		logic       rt_en;
		logic [2:0] rt_bit;
	} lane_ctrl_t;

endpackage

// ===== hdl/sobel_ram.sv =====
module sobel_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/sobel_lane.sv =====
module sobel_lane (
	input  logic                                  clk,
	input  logic [8:0][sobel_pkg::PIX_W-1:0]      pix,
	input  sobel_pkg::lane_ctrl_t                 ctrl,
	output logic [sobel_pkg::PIX_W-1:0]           mag
);

	// pix index is row * 3 + column, top left first.
	logic signed [10:0] gx;
	logic signed [10:0] gy;
	logic signed [20:0] gx_sq;
	logic signed [20:0] gy_sq;
	logic [sobel_pkg::SUM_W-1:0] s_q;
	logic [7:0] cand_q;
	logic [7:0] trial;
	logic [16:0] trial_sum;

	always_comb begin
		gx = $signed({3'b0, pix[2]}) + $signed({2'b0, pix[5], 1'b0}) + $signed({3'b0, pix[8]})
			- $signed({3'b0, pix[0]}) - $signed({2'b0, pix[3], 1'b0}) - $signed({3'b0, pix[6]});
		gy = $signed({3'b0, pix[6]}) + $signed({2'b0, pix[7], 1'b0}) + $signed({3'b0, pix[8]})
			- $signed({3'b0, pix[0]}) - $signed({2'b0, pix[1], 1'b0}) - $signed({3'b0, pix[2]});
		gx_sq = 21'(gx * gx);
		gy_sq = 21'(gy * gy);
	end

	// Greedy bit search for the largest m with m*m + m < s; the result is m + 1.
	assign trial = cand_q | 8'(1 << ctrl.rt_bit);
	assign trial_sum = 17'(17'(trial) * 17'(trial)) + 17'(trial);

	always_ff @(posedge clk) begin
		if (ctrl.sq_en) begin
			s_q <= sobel_pkg::SUM_W'(gx_sq) + sobel_pkg::SUM_W'(gy_sq);
			cand_q <= '0;
		end else if (ctrl.rt_en) begin
			if ({4'b0, trial_sum} < s_q) begin
				cand_q <= trial;
			end
		end
	end

	always_comb begin
		if (s_q > sobel_pkg::SAT_LIMIT) begin
			mag = sobel_pkg::MAG_MAX;
		end else if (s_q == '0) begin
			mag = '0;
		end else begin
			mag = cand_q + 8'd1;
		end
	end

endmodule

// ===== hdl/rgb_sobel_edge_magnitude.sv =====
// RGB Sobel edge magnitude.
//
// Pixels of one frame enter in raster order on the s_axis channel; tdata holds
// red, green and blue, and tuser selects a pixel beat (0) or a drain beat (1).
// Each beat that completes a 3x3 window yields one result beat on m_axis with
// the rounded gradient magnitude of each channel, tlast on the last pixel of a
// row and tuser on the last pixel of the frame. Results trail the input by one
// row plus one pixel; after the last pixel of a frame, one drain beat per
// pending result flushes the rest. Drain beats before the frame is complete and
// pixel beats while results are still pending are dropped. The user must write
// the frame size through the cfg port while the block is idle; the block does not enforce it.
//
// A beat that yields no result leaves tready high. A beat that yields one holds
// tready low until its result is valid on m_axis, through these steps in order:
// acceptance, the line store read and window load (done twice at a row start,
// which loads two columns), one squaring step, an 8-step square root search that
// the three channel lanes run side by side, and the move into the output register.
// While the receiver stalls, the last result stays in the output register; the
// next beat is still accepted and computed, and its result then waits for the
// register with tready low until the receiver takes the earlier one.
// Reset clears counters and the window; the line stores need no clearing
// because rows outside the frame are masked to zero.
module rgb_sobel_edge_magnitude #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [23:0]                     s_axis_tdata,  // red_in, green_in, blue_in
	input  logic                            s_axis_tuser,  // kind
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [23:0]                     m_axis_tdata,  // red_out, green_out, blue_out
	output logic                            m_axis_tlast,  // line_end
	output logic                            m_axis_tuser   // frame_end
);

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned PW = sobel_pkg::PIX_W;

	sobel_pkg::state_t state_q, state_nxt;

	logic [sobel_pkg::CFG_W-1:0] width_cfg_q, height_cfg_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	logic [WW-1:0] in_col_q, out_col_q, fetch_q, col_w;
	logic [HW-1:0] in_row_q, out_row_q;
	logic done_q, first_q;
	logic [2:0] bit_q;
	logic [sobel_pkg::RGB_W-1:0] win_q [3][3];

	logic in_acc, is_drain, wr_en, emit_go, out_free;
	logic [1:0] wr_sel, mid_sel, up_sel, lo_sel;
	logic [sobel_pkg::RGB_W-1:0] wr_data;
	logic [sobel_pkg::RGB_W-1:0] rd_data [4];
	logic [sobel_pkg::RGB_W-1:0] col_new [3];
	logic rd_en;
	logic pix_ready;
	logic line_last, frame_last;
	sobel_pkg::lane_ctrl_t lane_ctrl;
	logic [PW-1:0] mag [3];
	logic [8:0][PW-1:0] lane_pix [3];

	// Effective frame size: zero acts as one, oversize clamps to the maximum.
	always_comb begin
		if (width_cfg_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_cfg_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_cfg_q);
		end
		if (height_cfg_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_cfg_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q <= sobel_pkg::CFG_W'(640);
			height_cfg_q <= sobel_pkg::CFG_W'(480);
		end else if (cfg_we) begin
			if (cfg_index == sobel_pkg::CFG_IMAGE_WIDTH) begin
				width_cfg_q <= cfg_data;
			end else begin
				height_cfg_q <= cfg_data;
			end
		end
	end

	assign is_drain = (s_axis_tuser == sobel_pkg::KIND_DRAIN);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign col_w = (in_col_q >= w_eff) ? w_eff - WW'(1) : in_col_q;
	assign wr_en = in_acc && !is_drain && !done_q;
	assign pix_ready = (32'(in_row_q) >= 32'd2) || (in_row_q == HW'(1) && col_w != '0);
	assign emit_go = in_acc && (is_drain ? done_q : (!done_q && pix_ready));
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign wr_sel = 2'(in_row_q);
	assign wr_data = {s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0]};

	assign mid_sel = 2'(out_row_q);
	assign up_sel = mid_sel - 2'd1;
	assign lo_sel = mid_sel + 2'd1;

	// One line store per row modulo four, so the three window rows come
	// from three different stores in the same cycle.
	for (genvar g = 0; g < 4; g++) begin : g_row
		sobel_ram #(
			.WIDTH(sobel_pkg::RGB_W),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk    (clk),
			.wr_en  (wr_en && wr_sel == 2'(g)),
			.wr_addr(AW'(col_w)),
			.wr_data(wr_data),
			.rd_en  (rd_en),
			.rd_addr(AW'(fetch_q)),
			.rd_data(rd_data[g])
		);
	end

	// New window column with rows and columns outside the frame forced to zero.
	always_comb begin
		col_new[0] = (out_row_q != '0 && fetch_q < w_eff) ? rd_data[up_sel] : '0;
		col_new[1] = (fetch_q < w_eff) ? rd_data[mid_sel] : '0;
		col_new[2] = (32'(out_row_q) + 32'd1 < 32'(h_eff) && fetch_q < w_eff) ?
			rd_data[lo_sel] : '0;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sobel_pkg::ST_IDLE: if (emit_go) state_nxt = sobel_pkg::ST_RD;
			sobel_pkg::ST_RD:   state_nxt = sobel_pkg::ST_LD;
			sobel_pkg::ST_LD:   state_nxt = first_q ? sobel_pkg::ST_RD : sobel_pkg::ST_SQ;
			sobel_pkg::ST_SQ:   state_nxt = sobel_pkg::ST_ROOT;
			sobel_pkg::ST_ROOT: if (bit_q == 3'd0) state_nxt = sobel_pkg::ST_OUT;
			sobel_pkg::ST_OUT:  if (out_free) state_nxt = sobel_pkg::ST_IDLE;
			default:            state_nxt = sobel_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_en = 1'b0;
		lane_ctrl = '0;
		case (state_q)
			sobel_pkg::ST_IDLE: s_axis_tready = 1'b1;
			sobel_pkg::ST_RD:   rd_en = 1'b1;
			sobel_pkg::ST_SQ:   lane_ctrl.sq_en = 1'b1;
			sobel_pkg::ST_ROOT: begin
				lane_ctrl.rt_en = 1'b1;
				lane_ctrl.rt_bit = bit_q;
			end
			default: ;
		endcase
	end

	assign line_last = (32'(out_col_q) + 32'd1 >= 32'(w_eff));
	assign frame_last = line_last && (32'(out_row_q) + 32'd1 >= 32'(h_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sobel_pkg::ST_IDLE;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			done_q <= 1'b0;
			first_q <= 1'b0;
			fetch_q <= '0;
			bit_q <= '0;
			m_axis_tvalid <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				if (32'(col_w) + 32'd1 >= 32'(w_eff)) begin
					in_col_q <= '0;
					if (32'(in_row_q) + 32'd1 >= 32'(h_eff)) begin
						in_row_q <= '0;
						done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + HW'(1);
					end
				end else begin
					in_col_q <= col_w + WW'(1);
				end
			end
			if (state_q == sobel_pkg::ST_IDLE && emit_go) begin
				first_q <= (out_col_q == '0);
				fetch_q <= (out_col_q == '0) ? '0 : out_col_q + WW'(1);
				if (out_col_q == '0) begin
					for (int r = 0; r < 3; r++) begin
						for (int c = 0; c < 3; c++) begin
							win_q[r][c] <= '0;
						end
					end
				end
			end
			if (state_q == sobel_pkg::ST_LD) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
					win_q[r][2] <= col_new[r];
				end
				if (first_q) begin
					first_q <= 1'b0;
					fetch_q <= fetch_q + WW'(1);
				end
			end
			if (state_q == sobel_pkg::ST_SQ) begin
				bit_q <= 3'd7;
			end
			if (state_q == sobel_pkg::ST_ROOT && bit_q != 3'd0) begin
				bit_q <= bit_q - 3'd1;
			end
			if (state_q == sobel_pkg::ST_OUT && out_free) begin
				m_axis_tvalid <= 1'b1;
				if (line_last) begin
					out_col_q <= '0;
					if (32'(out_row_q) + 32'd1 >= 32'(h_eff)) begin
						out_row_q <= '0;
						done_q <= 1'b0;
					end else begin
						out_row_q <= out_row_q + HW'(1);
					end
				end else begin
					out_col_q <= out_col_q + WW'(1);
				end
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output register payload; merges the three lane results.
	always_ff @(posedge clk) begin
		if (state_q == sobel_pkg::ST_OUT && out_free) begin
			m_axis_tdata <= {mag[2], mag[1], mag[0]};
			m_axis_tlast <= line_last;
			m_axis_tuser <= frame_last;
		end
	end

	// Three channel lanes, lane 0 to lane 2: blue, green, red.
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		always_comb begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					lane_pix[ch][r*3+c] = win_q[r][c][ch*PW +: PW];
				end
			end
		end
		sobel_lane u_lane (
			.clk (clk),
			.pix (lane_pix[ch]),
			.ctrl(lane_ctrl),
			.mag (mag[ch])
		);
	end

	// A line store is never written once the frame input is complete.
	a_no_write_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !done_q) else $error("line store written after frame end");

	// The frame-complete flag only rises on a pixel write.
	a_done_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(wr_en)) else $error("frame end without pixel write");

	// A finished result waits while the output register is still occupied.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sobel_pkg::ST_OUT && !out_free) |=> state_q == sobel_pkg::ST_OUT)
		else $error("result dropped while output register busy");

endmodule
